/* rtl/core/tlsc_pkg.sv */
// tlsc_pkg: shared types and constants for the text line splitter
// holds character codes, line classes, result record and result queue sizing
// no dependencies
package tlsc_pkg;

    localparam int LEN_W = 9;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;

    localparam int RES_Q_DEPTH = 4;
    localparam int RES_Q_AW    = 2;
    localparam int RES_Q_CW    = 3;

    typedef enum logic [1:0] {
        CLASS_EMPTY   = 2'd0,
        CLASS_COMMENT = 2'd1,
        CLASS_COMMAND = 2'd2
    } line_class_t;

    typedef struct packed {
        logic [31:0]      line_number;
        logic [31:0]      start_offset;
        logic [LEN_W-1:0] content_length;
        logic [LEN_W-1:0] raw_length;
        logic             ends_with_newline;
        line_class_t      line_class;
        logic             last_of_run;
    } line_res_t;

    typedef struct packed {
        logic [1:0] count;
        line_res_t  first;
        line_res_t  second;
    } res_push_t;

endpackage

/* rtl/core/tlsc_if.sv */
// tlsc_byte_if and tlsc_line_if: valid/ready channels for bytes in and lines out
// depends on tlsc_pkg
interface tlsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface tlsc_line_if;
    import tlsc_pkg::*;

    logic             valid;
    logic             ready;
    logic [31:0]      line_number;
    logic [31:0]      start_offset;
    logic [LEN_W-1:0] content_length;
    logic [LEN_W-1:0] raw_length;
    logic             ends_with_newline;
    logic [1:0]       line_class;
    logic             last_of_run;

    modport source (output valid, output line_number, output start_offset,
                    output content_length, output raw_length, output ends_with_newline,
                    output line_class, output last_of_run, input ready);
    modport sink (input valid, input line_number, input start_offset,
                  input content_length, input raw_length, input ends_with_newline,
                  input line_class, input last_of_run, output ready);
endinterface

/* rtl/core/tlsc_core.sv */
// tlsc_core: per-byte line tracking, terminator handling and classification
// produces up to two line results per byte; depends on tlsc_pkg
module tlsc_core #(
    parameter int MAX_LINE_BYTES = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          data_byte,
    input  logic                end_of_file,
    output tlsc_pkg::res_push_t push
);
    import tlsc_pkg::*;

    localparam int LW = $clog2(MAX_LINE_BYTES + 1);

    localparam logic [1:0] TERM_NONE = 2'd0;
    localparam logic [1:0] TERM_ONE  = 2'd1;
    localparam logic [1:0] TERM_TWO  = 2'd2;

    typedef struct packed {
        logic [31:0]   ln;
        logic [31:0]   ls;
        logic [LW-1:0] cl;
        line_class_t   cls;
    } track_t;

    localparam track_t TRK_RESET = '{ln: 32'd1, ls: 32'd0, cl: '0, cls: CLASS_EMPTY};

    track_t     trk_reg;
    track_t     trk_next;
    logic       cr_pend_reg;
    logic       cr_pend_next;
    track_t     work;
    logic       handled;
    logic [1:0] n;
    line_res_t  r0;
    line_res_t  r1;

    function automatic line_res_t make_res(track_t t, logic [1:0] term);
        logic [31:0] raw;
        line_res_t   r;
        raw = 32'(t.cl) + 32'(term);
        r.line_number       = t.ln;
        r.start_offset      = t.ls;
        r.content_length    = LEN_W'(t.cl);
        r.raw_length        = raw[LEN_W-1:0];
        r.ends_with_newline = (term != TERM_NONE);
        r.line_class        = t.cls;
        r.last_of_run       = 1'b0;
        return r;
    endfunction

    function automatic track_t next_line(track_t t, logic [1:0] term);
        track_t o;
        o.ln  = t.ln + 32'd1;
        o.ls  = t.ls + 32'(t.cl) + 32'(term);
        o.cl  = '0;
        o.cls = CLASS_EMPTY;
        return o;
    endfunction

    always_comb
    begin
        work         = trk_reg;
        cr_pend_next = cr_pend_reg;
        handled      = 1'b0;
        n            = 2'd0;
        r0           = '0;
        r1           = '0;

        if (cr_pend_reg)
        begin
            cr_pend_next = 1'b0;
            if (data_byte == CHAR_LF)
            begin
                r0      = make_res(work, TERM_TWO);
                work    = next_line(work, TERM_TWO);
                n       = 2'd1;
                handled = 1'b1;
            end
            else
            begin
                r0   = make_res(work, TERM_ONE);
                work = next_line(work, TERM_ONE);
                n    = 2'd1;
            end
        end

        if (!handled)
        begin
            if (data_byte == CHAR_LF)
            begin
                if (n == 2'd0)
                    r0 = make_res(work, TERM_ONE);
                else
                    r1 = make_res(work, TERM_ONE);
                work = next_line(work, TERM_ONE);
                n    = n + 2'd1;
            end
            else if (data_byte == CHAR_CR)
            begin
                if (end_of_file)
                begin
                    if (n == 2'd0)
                        r0 = make_res(work, TERM_ONE);
                    else
                        r1 = make_res(work, TERM_ONE);
                    work = next_line(work, TERM_ONE);
                    n    = n + 2'd1;
                end
                else
                begin
                    cr_pend_next = 1'b1;
                end
            end
            else
            begin
                // overlong line: close the full piece before taking this byte
                if (work.cl >= LW'(MAX_LINE_BYTES))
                begin
                    if (n == 2'd0)
                        r0 = make_res(work, TERM_NONE);
                    else
                        r1 = make_res(work, TERM_NONE);
                    work = next_line(work, TERM_NONE);
                    n    = n + 2'd1;
                end
                work.cl = work.cl + LW'(1);
                if (work.cls == CLASS_EMPTY && data_byte != CHAR_SPACE
                    && data_byte != CHAR_TAB)
                begin
                    work.cls = (data_byte == CHAR_SEMI) ? CLASS_COMMENT : CLASS_COMMAND;
                end
                if (end_of_file)
                begin
                    if (n == 2'd0)
                        r0 = make_res(work, TERM_NONE);
                    else
                        r1 = make_res(work, TERM_NONE);
                    work = next_line(work, TERM_NONE);
                    n    = n + 2'd1;
                end
            end
        end

        if (n == 2'd1)
            r0.last_of_run = 1'b1;
        if (n == 2'd2)
            r1.last_of_run = 1'b1;

        if (end_of_file)
        begin
            trk_next     = TRK_RESET;
            cr_pend_next = 1'b0;
        end
        else
        begin
            trk_next = work;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trk_reg     <= TRK_RESET;
            cr_pend_reg <= 1'b0;
        end
        else if (advance)
        begin
            trk_reg     <= trk_next;
            cr_pend_reg <= cr_pend_next;
        end
    end

    assign push.count  = advance ? n : 2'd0;
    assign push.first  = r0;
    assign push.second = r1;

endmodule

/* rtl/core/tlsc_res_fifo.sv */
// tlsc_res_fifo: small result queue, takes up to two results per cycle, gives one
// drives the line output channel; depends on tlsc_pkg and tlsc_line_if
module tlsc_res_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  tlsc_pkg::res_push_t push,
    output logic                space,
    tlsc_line_if.source         lines
);
    import tlsc_pkg::*;

    line_res_t             q_reg [RES_Q_DEPTH];
    logic [RES_Q_AW-1:0]   wr_ptr_reg;
    logic [RES_Q_AW-1:0]   wr_ptr_next;
    logic [RES_Q_AW-1:0]   wr_ptr_inc;
    logic [RES_Q_AW-1:0]   rd_ptr_reg;
    logic [RES_Q_AW-1:0]   rd_ptr_next;
    logic [RES_Q_CW-1:0]   count_reg;
    logic [RES_Q_CW-1:0]   count_next;
    logic                  pop;
    line_res_t             head;

    assign wr_ptr_inc  = wr_ptr_reg + RES_Q_AW'(1);
    assign pop         = lines.valid && lines.ready;
    assign wr_ptr_next = wr_ptr_reg + RES_Q_AW'(push.count);
    assign rd_ptr_next = rd_ptr_reg + RES_Q_AW'(pop);
    assign count_next  = count_reg + RES_Q_CW'(push.count) - RES_Q_CW'(pop);
    assign space       = (count_reg <= RES_Q_CW'(RES_Q_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            q_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            q_reg[wr_ptr_inc] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head                    = q_reg[rd_ptr_reg];
    assign lines.valid             = (count_reg != '0);
    assign lines.line_number       = head.line_number;
    assign lines.start_offset      = head.start_offset;
    assign lines.content_length    = head.content_length;
    assign lines.raw_length        = head.raw_length;
    assign lines.ends_with_newline = head.ends_with_newline;
    assign lines.line_class        = head.line_class;
    assign lines.last_of_run       = head.last_of_run;

endmodule

/* rtl/core/text_line_splitter_classifier_top.sv */
// text_line_splitter_classifier_top: byte register, line tracker and result queue
// path: byte register, line tracker, then result queue whose head drives the output
// throughput: one byte per cycle while the result queue has room for two results;
//   two results of a byte leave one at a time through the single-read four-entry queue
// reset: line counter to 1, offsets and lengths to 0, no pending CR, queue empty
module text_line_splitter_classifier_top #(
    parameter int MAX_LINE_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    tlsc_byte_if.sink   data,
    tlsc_line_if.source lines
);
    import tlsc_pkg::*;

    logic      in_vld_reg;
    logic [7:0] in_byte_reg;
    logic      in_eof_reg;
    logic      take;
    logic      q_space;
    res_push_t push;

    assign take       = in_vld_reg && q_space;
    assign data.ready = !in_vld_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (data.valid && data.ready)
            in_vld_reg <= 1'b1;
        else if (take)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (data.valid && data.ready)
        begin
            in_byte_reg <= data.data_byte;
            in_eof_reg  <= data.end_of_file;
        end
    end

    tlsc_core #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (take),
        .data_byte   (in_byte_reg),
        .end_of_file (in_eof_reg),
        .push        (push)
    );

    tlsc_res_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .space (q_space),
        .lines (lines)
    );

endmodule

/* rtl/core/tlsc_checker.sv */
// tlsc_checker: port-level checks on the line output channel of the top level
// bound to text_line_splitter_classifier_top; no package dependency
module tlsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        lines_valid,
    input logic        lines_ready,
    input logic [31:0] line_number,
    input logic [31:0] start_offset,
    input logic [8:0]  content_length,
    input logic [8:0]  raw_length,
    input logic        ends_with_newline,
    input logic [1:0]  line_class,
    input logic        last_of_run
);
    logic [85:0] payload;

    assign payload = {line_number, start_offset, content_length, raw_length,
                      ends_with_newline, line_class, last_of_run};

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !lines_valid)
        else $error("line output valid during reset");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        lines_valid && !lines_ready |=> lines_valid)
        else $error("line output valid dropped before transfer");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        lines_valid && !lines_ready |=> $stable(payload))
        else $error("line output payload changed while stalled");

    // a result that is not the last of its byte is followed at once by the next line
    a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
        lines_valid && lines_ready && !last_of_run
        |=> lines_valid && line_number == $past(line_number) + 32'd1)
        else $error("second result of a byte missing or misnumbered");

endmodule

bind text_line_splitter_classifier_top tlsc_checker u_tlsc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .lines_valid       (lines.valid),
    .lines_ready       (lines.ready),
    .line_number       (lines.line_number),
    .start_offset      (lines.start_offset),
    .content_length    (lines.content_length),
    .raw_length        (lines.raw_length),
    .ends_with_newline (lines.ends_with_newline),
    .line_class        (lines.line_class),
    .last_of_run       (lines.last_of_run)
);
